/* hdl/sfnf_pkg.sv */
`default_nettype none

package sfnf_pkg;

  // Formatted directory name length and fixed characters
  localparam int          SNAME_LEN  = 11;
  localparam int          CNT_W      = $clog2(SNAME_LEN + 1);
  localparam logic [7:0]  PAD_CHAR   = 8'h20;
  localparam logic [7:0]  SUBST_CHAR = 8'h5F;
  localparam logic [7:0]  DOT_CHAR   = 8'h2E;
  localparam logic [7:0]  NUL_CHAR   = 8'h00;
  localparam logic [7:0]  DEL_MARK   = 8'hE5;
  localparam logic [7:0]  DEL_ESC    = 8'h05;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_word_t;

  // Byte 0 of the name sits in the low lane
  typedef logic [SNAME_LEN-1:0][7:0] name_buf_t;

  function automatic logic is_allowed(input logic [7:0] b);
    logic ok;
    begin
      ok = 1'b0;
      if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h30 && b <= 8'h39)) begin
        ok = 1'b1;
      end
      unique case (b)
        8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29,
        8'h2D, 8'h40, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7D, 8'h7E: ok = 1'b1;
        default: ;
      endcase
      return ok;
    end
  endfunction

  function automatic logic [7:0] map_char(input logic [7:0] b);
    logic [7:0] r;
    begin
      priority if (b == DEL_MARK) begin
        r = DEL_ESC;
      end else if (b[7] || is_allowed(b)) begin
        r = b;
      end else if (b >= 8'h61 && b <= 8'h7A) begin
        r = b - 8'h20;
      end else begin
        r = SUBST_CHAR;
      end
      return r;
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/short_filename_formatter.sv */
// Short file name formatter: raw file name in, FAT 8.3 directory name out.
//
// Input channel (name_valid / name_stall / name_word): one name byte per
// word, is_last set on the final byte. A byte is taken at a rising edge
// with name_valid high and name_stall low.
// Output channel (entry_valid / entry_stall / entry_word): eleven words per
// name, space padded, out_last set on the eleventh.
//
// Output: the last name byte is registered in the input register, then
// loaded into the emit register once it is free; the words then follow
// one per cycle while not stalled. Throughput: one name byte per cycle while
// name_stall is low. Each name is shifted out word by word on the emit shift
// register; a second name is parsed while the previous one is still being
// shifted out.
// Reset (rst, synchronous): parse state cleared to an all-space buffer,
// input register and emit register emptied.
// Receiver stall: the emit word holds; once the input register holds a
// last byte that cannot hand off its name, name_stall rises until the emit
// register drains.
`default_nettype none

module short_filename_formatter #(
  parameter int NAME_CHARS = 8,
  parameter int EXT_CHARS  = 3
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                name_valid,
  output      logic                name_stall,
  input  wire sfnf_pkg::in_word_t  name_word,
  output      logic                entry_valid,
  input  wire logic                entry_stall,
  output      sfnf_pkg::out_word_t entry_word
);

  // input register
  logic                          in_full;
  sfnf_pkg::in_word_t            in_q;
  logic                          take;

  // emit shift register
  sfnf_pkg::name_buf_t           emit_buf;
  logic [sfnf_pkg::CNT_W-1:0]    emit_cnt;
  logic                          emit_free;
  logic                          load;
  sfnf_pkg::name_buf_t           image;

  // emitter can take a new name when empty or on its final accepted word
  assign emit_free = (emit_cnt == '0) ||
                     (emit_cnt == sfnf_pkg::CNT_W'(1) && !entry_stall);
  assign take       = in_full && (!in_q.is_last || emit_free);
  assign load       = take && in_q.is_last;
  assign name_stall = in_full && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!name_stall) begin
      in_full <= name_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!name_stall) begin
      in_q <= name_word;
    end
  end

  sfnf_parser #(
    .NAME_CHARS(NAME_CHARS),
    .EXT_CHARS (EXT_CHARS)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .word (in_q),
    .image(image)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_cnt <= '0;
    end else if (load) begin
      emit_cnt <= sfnf_pkg::CNT_W'(sfnf_pkg::SNAME_LEN);
    end else if (entry_valid && !entry_stall) begin
      emit_cnt <= emit_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      emit_buf <= image;
    end else if (entry_valid && !entry_stall) begin
      emit_buf <= {sfnf_pkg::PAD_CHAR, emit_buf[sfnf_pkg::SNAME_LEN-1:1]};
    end
  end

  assign entry_valid         = (emit_cnt != '0);
  assign entry_word.out_byte = emit_buf[0];
  assign entry_word.out_last = (emit_cnt == sfnf_pkg::CNT_W'(1));

endmodule

`default_nettype wire

/* hdl/sfnf_parser.sv */
`default_nettype none

// Parse state and 11-byte name buffer; one byte per take.
module sfnf_parser #(
  parameter int NAME_CHARS = 8,
  parameter int EXT_CHARS  = 3
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire sfnf_pkg::in_word_t word,
  output sfnf_pkg::name_buf_t    image
);

  localparam int LIMIT_MAX = (NAME_CHARS > EXT_CHARS) ? NAME_CHARS : EXT_CHARS;
  localparam int POS_W     = $clog2(LIMIT_MAX + 1);
  localparam int IDX_W     = $clog2(NAME_CHARS + LIMIT_MAX + 1);

  localparam logic [2:0] PH_FIRST = 3'd0;
  localparam logic [2:0] PH_DOT   = 3'd1;
  localparam logic [2:0] PH_NLEAD = 3'd2;
  localparam logic [2:0] PH_NAME  = 3'd3;
  localparam logic [2:0] PH_XLEAD = 3'd4;
  localparam logic [2:0] PH_EXT   = 3'd5;
  localparam logic [2:0] PH_SKIP  = 3'd6;

  sfnf_pkg::name_buf_t name_buf;
  sfnf_pkg::name_buf_t name_buf_next;
  logic [2:0]          phase;
  logic [2:0]          phase_next;
  logic [POS_W-1:0]    pos;
  logic [POS_W-1:0]    pos_next;
  logic [2:0]          eff;
  logic                put_en;
  logic [IDX_W-1:0]    put_base;
  logic [POS_W-1:0]    put_limit;
  logic [IDX_W-1:0]    idx;
  logic [7:0]          b;

  assign b = word.name_byte;

  always_comb begin
    name_buf_next = name_buf;
    phase_next    = phase;
    pos_next      = pos;
    put_en        = 1'b0;
    put_base      = '0;
    put_limit     = '0;
    eff           = (phase == PH_FIRST) ? PH_NLEAD : phase;

    priority if (phase == PH_FIRST && b == sfnf_pkg::DOT_CHAR) begin
      name_buf_next[0] = sfnf_pkg::DOT_CHAR;
      phase_next       = PH_DOT;
    end else if (phase == PH_DOT) begin
      if (b == sfnf_pkg::DOT_CHAR) begin
        name_buf_next[1] = sfnf_pkg::DOT_CHAR;
      end
      phase_next = PH_SKIP;
    end else if (eff >= PH_SKIP || b == sfnf_pkg::NUL_CHAR) begin
      phase_next = PH_SKIP;
    end else if (eff == PH_NLEAD || eff == PH_NAME) begin
      priority if (b == sfnf_pkg::DOT_CHAR) begin
        phase_next = PH_XLEAD;
        pos_next   = '0;
      end else if (eff == PH_NLEAD && b == sfnf_pkg::PAD_CHAR) begin
        phase_next = PH_NLEAD;
      end else begin
        phase_next = PH_NAME;
        put_en     = 1'b1;
        put_limit  = POS_W'(NAME_CHARS);
      end
    end else begin
      if (eff == PH_XLEAD && b == sfnf_pkg::PAD_CHAR) begin
        phase_next = PH_XLEAD;
      end else begin
        phase_next = PH_EXT;
        put_en     = 1'b1;
        put_base   = IDX_W'(NAME_CHARS);
        put_limit  = POS_W'(EXT_CHARS);
      end
    end

    // characters past the part limit or past the buffer are dropped
    idx = put_base + IDX_W'(pos);
    if (put_en && pos < put_limit) begin
      for (int i = 0; i < sfnf_pkg::SNAME_LEN; i++) begin
        if (idx == IDX_W'(i)) begin
          name_buf_next[i] = sfnf_pkg::map_char(b);
        end
      end
      pos_next = pos + 1'b1;
    end
  end

  assign image = name_buf_next;

  always_ff @(posedge clk) begin
    if (rst || (take && word.is_last)) begin
      name_buf <= {sfnf_pkg::SNAME_LEN{sfnf_pkg::PAD_CHAR}};
      phase    <= PH_FIRST;
      pos      <= '0;
    end else if (take) begin
      name_buf <= name_buf_next;
      phase    <= phase_next;
      pos      <= pos_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/sfnf_checker.sv */
`default_nettype none

module sfnf_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                name_valid,
  input wire logic                name_stall,
  input wire sfnf_pkg::in_word_t  name_word,
  input wire logic                entry_valid,
  input wire logic                entry_stall,
  input wire sfnf_pkg::out_word_t entry_word
);

  logic       name_done;
  logic       entry_done;
  logic [1:0] pending;
  logic [3:0] beat;

  assign name_done  = name_valid && !name_stall && name_word.is_last;
  assign entry_done = entry_valid && !entry_stall && entry_word.out_last;

  // names taken in but not yet fully delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, name_done} - {1'b0, entry_done};
    end
  end

  // word position inside the current output name
  always_ff @(posedge clk) begin
    if (rst || entry_done) begin
      beat <= '0;
    end else if (entry_valid && !entry_stall) begin
      beat <= beat + 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !entry_valid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    entry_valid && entry_stall |=> entry_valid && $stable(entry_word))
    else $error("stalled output word changed");

  a_eleven: assert property (@(posedge clk) disable iff (rst)
    entry_valid |-> (entry_word.out_last == (beat == 4'd10)))
    else $error("out_last not on the eleventh word");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    entry_valid |-> pending != 2'd0)
    else $error("output with no name pending");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two names in flight");

endmodule

bind short_filename_formatter sfnf_checker u_sfnf_checker (
  .clk        (clk),
  .rst        (rst),
  .name_valid (name_valid),
  .name_stall (name_stall),
  .name_word  (name_word),
  .entry_valid(entry_valid),
  .entry_stall(entry_stall),
  .entry_word (entry_word)
);

`default_nettype wire
